>>> sv/tcaa_pkg.sv
`default_nettype none

package tcaa_pkg;

    // Fixed widths and constants
    localparam int unsigned CFG_WIDTH           = 16;
    localparam int unsigned DUTY_WIDTH          = 8;
    localparam int unsigned DELAY_WIDTH_DEFAULT = 16;

    localparam logic [CFG_WIDTH-1:0]  DELAY_RESET = 16'd10;
    localparam logic [DUTY_WIDTH-1:0] DIM_STEP    = 8'd51;
    localparam logic [DUTY_WIDTH-1:0] DUTY_FULL   = 8'd255;

    // One scan of the switch levels
    typedef struct packed {
        logic tick;
        logic oil_input;
        logic filter_input;
        logic mute_switch;
        logic reset_switch;
        logic lamp_test_switch;
        logic dimmer_switch;
    } in_t;

    // Indicator drive for one scan
    typedef struct packed {
        logic                  oil_lamp;
        logic                  filter_lamp;
        logic                  horn;
        logic [DUTY_WIDTH-1:0] lamp_duty;
        logic                  lamp_test_active;
    } out_t;

    // Per-channel status after this scan's update
    typedef struct packed {
        logic latched;
        logic sound;
    } chan_status_t;

endpackage

`default_nettype wire

>>> sv/tcaa_channel.sv
`default_nettype none

module tcaa_channel #(
    parameter int unsigned DELAY_WIDTH = tcaa_pkg::DELAY_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           level,
    input  wire logic                           tick,
    input  wire logic                           mute,
    input  wire logic                           rst_sw,
    input  wire logic [tcaa_pkg::CFG_WIDTH-1:0] delay,
    output tcaa_pkg::chan_status_t              status
);
    import tcaa_pkg::*;

    localparam int unsigned CMP_W = (DELAY_WIDTH > CFG_WIDTH) ? DELAY_WIDTH : CFG_WIDTH;

    logic [DELAY_WIDTH-1:0] count_reg, count_next;
    logic                   expired_reg, expired_next;
    logic                   latched_reg, latched_next;
    logic                   silenced_reg, silenced_next;

    logic [DELAY_WIDTH-1:0] count_base;
    logic [DELAY_WIDTH-1:0] count_inc;
    logic                   hit;

    // Delay-on timer: cleared when the input drops, counts ticks while active
    always_comb
    begin
        count_base = level ? count_reg : '0;
        count_inc  = count_base + {{(DELAY_WIDTH-1){1'b0}}, 1'b1};
        hit = (CMP_W'(count_inc) >= CMP_W'(delay))
              || (count_inc == {DELAY_WIDTH{1'b1}})
              || (count_inc == '0);
        count_next   = count_base;
        expired_next = level & expired_reg;
        if (tick && level)
        begin
            if (hit)
            begin
                expired_next = 1'b1;
                count_next   = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    // Alarm latch and mute
    always_comb
    begin
        latched_next  = expired_next | (latched_reg & ~rst_sw);
        silenced_next = latched_next & (mute | silenced_reg) & ~(expired_next & rst_sw);
        status.latched = latched_next;
        status.sound   = latched_next & ~silenced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            expired_reg  <= 1'b0;
            latched_reg  <= 1'b0;
            silenced_reg <= 1'b0;
        end
        else if (en)
        begin
            count_reg    <= count_next;
            expired_reg  <= expired_next;
            latched_reg  <= latched_next;
            silenced_reg <= silenced_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/two_channel_alarm_annunciator.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------
// in       | in_valid / in_ready     | in_data  (tcaa_pkg::in_t)
// out      | out_valid / out_ready   | out_data (tcaa_pkg::out_t)
// cfg      | cfg_wr_en, no stall     | cfg_wr_data (alarm delay, ticks)
//
// One request per cycle sustained while out_ready is high; the result passes
// through the input register, then the result register.
// State is updated when a request moves from the input register to the
// result register, which happens whenever the result register is empty or
// being read. A stalled output holds its result while one more request waits
// in the input register. Async reset: delay = 10 ticks, duty = 255, no alarms.
`default_nettype none

module two_channel_alarm_annunciator #(
    parameter int unsigned DELAY_WIDTH = tcaa_pkg::DELAY_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire tcaa_pkg::in_t                  in_data,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output tcaa_pkg::out_t                      out_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tcaa_pkg::CFG_WIDTH-1:0] cfg_wr_data
);
    import tcaa_pkg::*;

    logic                  in_valid_reg;
    in_t                   in_reg;
    logic                  out_valid_reg;
    out_t                  out_reg, out_next;
    logic [CFG_WIDTH-1:0]  delay_reg;
    logic [DUTY_WIDTH-1:0] dim_level_reg, dim_level_next;
    logic                  advance;
    logic                  out_free;
    chan_status_t          oil_status;
    chan_status_t          filter_status;

    // Pipeline control
    assign out_free = ~out_valid_reg | out_ready;
    assign advance  = in_valid_reg & out_free;
    assign in_ready = ~in_valid_reg | out_free;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= DELAY_RESET;
        else if (cfg_wr_en)
            delay_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
    end

    // Alarm channels
    tcaa_channel #(.DELAY_WIDTH(DELAY_WIDTH)) u_oil (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .level  (in_reg.oil_input),
        .tick   (in_reg.tick),
        .mute   (in_reg.mute_switch),
        .rst_sw (in_reg.reset_switch),
        .delay  (delay_reg),
        .status (oil_status)
    );

    tcaa_channel #(.DELAY_WIDTH(DELAY_WIDTH)) u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .level  (in_reg.filter_input),
        .tick   (in_reg.tick),
        .mute   (in_reg.mute_switch),
        .rst_sw (in_reg.reset_switch),
        .delay  (delay_reg),
        .status (filter_status)
    );

    // Dimmer step, frozen during lamp check
    always_comb
    begin
        dim_level_next = dim_level_reg;
        if (!in_reg.lamp_test_switch && in_reg.dimmer_switch)
        begin
            if (dim_level_reg == '0)
                dim_level_next = DUTY_FULL;
            else
                dim_level_next = dim_level_reg - DIM_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_level_reg <= DUTY_FULL;
        else if (advance)
            dim_level_reg <= dim_level_next;
    end

    // Result assembly
    always_comb
    begin
        out_next.oil_lamp         = oil_status.latched | in_reg.lamp_test_switch;
        out_next.filter_lamp      = filter_status.latched | in_reg.lamp_test_switch;
        out_next.horn             = oil_status.sound | filter_status.sound
                                    | in_reg.lamp_test_switch;
        out_next.lamp_duty        = in_reg.lamp_test_switch ? DUTY_FULL : dim_level_reg;
        out_next.lamp_test_active = in_reg.lamp_test_switch;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> sv/tcaa_checker.sv
`default_nettype none

module tcaa_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire tcaa_pkg::in_t                  in_data,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire tcaa_pkg::out_t                 out_data
);
    import tcaa_pkg::*;

    // Waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("request changed while waiting");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Lamp check forces every indicator
    a_lamp_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.lamp_test_active |->
            out_data.oil_lamp && out_data.filter_lamp && out_data.horn
            && (out_data.lamp_duty == DUTY_FULL))
        else $error("lamp check did not force indicators");

    // Horn only sounds for a latched alarm
    a_horn_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.lamp_test_active && out_data.horn |->
            out_data.oil_lamp || out_data.filter_lamp)
        else $error("horn without latched alarm");

    // Empty output stage never blocks input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind two_channel_alarm_annunciator tcaa_checker u_tcaa_checker (.*);

`default_nettype wire
